FILE: rtl/mtt_pkg.sv
`timescale 1ns / 1ps

package mtt_pkg;

	// item field widths
	localparam int POS_W  = 21;
	localparam int TGT_W  = 12;
	localparam int SPD_W  = 16;
	localparam int TIME_W = 32;
	localparam int HEAD_W = 16;

	// slave tdata layout, lowest bit first
	localparam int IX_CX  = 0;
	localparam int IX_CY  = IX_CX + POS_W;
	localparam int IX_TX  = IX_CY + POS_W;
	localparam int IX_TY  = IX_TX + TGT_W;
	localparam int IX_SPD = IX_TY + TGT_W;
	localparam int IX_DLY = IX_SPD + SPD_W;
	localparam int IX_NOW = IX_DLY + TIME_W;
	localparam int IN_USED_W = IX_NOW + TIME_W;
	localparam int S_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// master tdata layout, lowest bit first
	localparam int OX_NX  = 0;
	localparam int OX_NY  = OX_NX + POS_W;
	localparam int OX_HD  = OX_NY + POS_W;
	localparam int OX_RCH = OX_HD + HEAD_W;
	localparam int OX_ACT = OX_RCH + 1;
	localparam int OUT_USED_W = OX_ACT + 1;
	localparam int M_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

	// position limits
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// angle arithmetic: accumulator in 2^-16 degree, result in 1/128 degree
	localparam int PRESCALE = 8;
	localparam int Z_W      = 26;
	localparam int ATAN_N   = 24;
	localparam int HEAD_SH  = 9;
	localparam logic signed [Z_W-1:0] HEAD_RND  = Z_W'(1 << (HEAD_SH - 1));
	localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 * 65536);
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = HEAD_W'(23040);

	// quotient bits of one step component
	localparam int Q_W = SPD_W + 1;

	// atan(2^-i) in degrees times 2^16
	function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
		logic signed [Z_W-1:0] val;
		case (idx)
			0:  val = Z_W'(2949120);
			1:  val = Z_W'(1740967);
			2:  val = Z_W'(919879);
			3:  val = Z_W'(466945);
			4:  val = Z_W'(234379);
			5:  val = Z_W'(117304);
			6:  val = Z_W'(58666);
			7:  val = Z_W'(29335);
			8:  val = Z_W'(14668);
			9:  val = Z_W'(7334);
			10: val = Z_W'(3667);
			11: val = Z_W'(1833);
			12: val = Z_W'(917);
			13: val = Z_W'(458);
			14: val = Z_W'(229);
			15: val = Z_W'(115);
			16: val = Z_W'(57);
			17: val = Z_W'(29);
			18: val = Z_W'(14);
			19: val = Z_W'(7);
			20: val = Z_W'(4);
			21: val = Z_W'(2);
			22: val = Z_W'(1);
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

FILE: rtl/move_toward_target_step_unit.sv
`timescale 1ns / 1ps
// throughput: one item per cycle; the whole pipeline advances when the output
// register is empty or taken, so a held result stalls every stage
// reset: arst_n clears all valid bits at once, no result is pending afterwards

module move_toward_target_step_unit #(
	parameter int FRAC_BITS     = 8,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cur_x, cur_y, target_x, target_y, plane_speed, launch_delay, now_time
	input  logic [mtt_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// new_x, new_y, heading, reached, active
	output logic [mtt_pkg::M_DATA_W-1:0]  m_tdata
);

	localparam int POS_W = mtt_pkg::POS_W;
	localparam int TGT_W = mtt_pkg::TGT_W;
	localparam int SPD_W = mtt_pkg::SPD_W;
	localparam int HD_W  = mtt_pkg::HEAD_W;
	localparam int Q_W   = mtt_pkg::Q_W;
	localparam int TX_W  = TGT_W + FRAC_BITS;
	localparam int D_W   = ((TX_W > POS_W) ? TX_W : POS_W) + 1;
	localparam int SQ_W  = 2 * D_W;
	localparam int P_W   = D_W + SPD_W;
	localparam int N_W   = P_W + 1;
	localparam int DEN_W = D_W + 1;
	localparam int X_W   = D_W + 1;
	localparam int E_W   = D_W + 2;
	localparam int ESQ_W = 2 * E_W;
	localparam int RC_W  = ESQ_W + 3;
	localparam int BASE_W = 2 * POS_W + 2 * TGT_W + SPD_W + 1;
	localparam int SBA_W = BASE_W + 2 * D_W;
	localparam int SBB_W = BASE_W + HD_W + 2 * P_W + 3;
	localparam int SBC_W = BASE_W + HD_W + 2;
	localparam logic [SQ_W-1:0] NORM_LIM = SQ_W'(4) << (2 * FRAC_BITS);

	logic en;

	// input fields
	logic signed [POS_W-1:0] in_cx, in_cy;
	logic signed [TGT_W-1:0] in_tgx, in_tgy;
	logic [SPD_W-1:0]        in_spd;
	logic [31:0]             in_dly, in_now;
	logic signed [D_W-1:0]   in_dx, in_dy;

	// stage 1
	logic                    v_s1, act_s1;
	logic signed [POS_W-1:0] cx_s1, cy_s1;
	logic signed [TGT_W-1:0] tgx_s1, tgy_s1;
	logic [SPD_W-1:0]        spd_s1;
	logic signed [D_W-1:0]   dx_s1, dy_s1;

	// cordic outputs
	logic                    v_c, act_c;
	logic [SBA_W-1:0]        sba_in, sba_out;
	logic signed [HD_W-1:0]  head_c;
	logic signed [POS_W-1:0] cx_c, cy_c;
	logic signed [TGT_W-1:0] tgx_c, tgy_c;
	logic [SPD_W-1:0]        spd_c;
	logic signed [D_W-1:0]   dx_c, dy_c;
	logic [D_W-1:0]          adx_c, ady_c;

	// stage 2
	logic                    v_s2, act_s2, negx_s2, negy_s2;
	logic signed [POS_W-1:0] cx_s2, cy_s2;
	logic signed [TGT_W-1:0] tgx_s2, tgy_s2;
	logic [SPD_W-1:0]        spd_s2;
	logic signed [HD_W-1:0]  head_s2;
	logic [SQ_W-1:0]         dxsq_s2, dysq_s2;
	logic [P_W-1:0]          pax_s2, pay_s2;

	// stage 3
	logic                    v_s3, act_s3, negx_s3, negy_s3, norm_s3;
	logic signed [POS_W-1:0] cx_s3, cy_s3;
	logic signed [TGT_W-1:0] tgx_s3, tgy_s3;
	logic [SPD_W-1:0]        spd_s3;
	logic signed [HD_W-1:0]  head_s3;
	logic [SQ_W-1:0]         sumsq_s3;
	logic [P_W-1:0]          pax_s3, pay_s3;

	// sqrt outputs
	logic                    v_r, act_r, negx_r, negy_r, norm_r;
	logic [SBB_W-1:0]        sbb_in, sbb_out;
	logic [D_W-1:0]          dist_r;
	logic signed [POS_W-1:0] cx_r, cy_r;
	logic signed [TGT_W-1:0] tgx_r, tgy_r;
	logic [SPD_W-1:0]        spd_r;
	logic signed [HD_W-1:0]  head_r;
	logic [P_W-1:0]          pax_r, pay_r;
	logic [DEN_W-1:0]        den_r, half_r;

	// stage 4
	logic                    v_s4, act_s4, negx_s4, negy_s4;
	logic signed [POS_W-1:0] cx_s4, cy_s4;
	logic signed [TGT_W-1:0] tgx_s4, tgy_s4;
	logic [SPD_W-1:0]        spd_s4;
	logic signed [HD_W-1:0]  head_s4;
	logic [N_W-1:0]          numx_s4, numy_s4;
	logic [DEN_W-1:0]        den_s4;

	// divider outputs
	logic                    v_d, act_d, negx_d, negy_d;
	logic [SBC_W-1:0]        sbc_in, sbc_out;
	logic [Q_W-1:0]          qx_d, qy_d;
	logic signed [POS_W-1:0] cx_d, cy_d;
	logic signed [TGT_W-1:0] tgx_d, tgy_d;
	logic [SPD_W-1:0]        spd_d;
	logic signed [HD_W-1:0]  head_d;
	logic signed [Q_W:0]     sx_d, sy_d;
	logic signed [X_W-1:0]   nx_d, ny_d, tx_d, ty_d;

	// stage 5
	logic                    v_s5, act_s5;
	logic signed [POS_W-1:0] cx_s5, cy_s5;
	logic [SPD_W-1:0]        spd_s5;
	logic signed [HD_W-1:0]  head_s5;
	logic signed [X_W-1:0]   nx_s5, ny_s5, tx_s5, ty_s5;
	logic signed [E_W-1:0]   ex_s5, ey_s5;

	// stage 6
	logic                    v_s6, act_s6;
	logic signed [POS_W-1:0] cx_s6, cy_s6;
	logic signed [HD_W-1:0]  head_s6;
	logic signed [X_W-1:0]   nx_s6, ny_s6, tx_s6, ty_s6;
	logic [ESQ_W-1:0]        exsq_s6, eysq_s6;
	logic [2*SPD_W-1:0]      spdsq_s6;

	// output stage
	logic                    rch_6;
	logic [RC_W-1:0]         rem4_6;
	logic signed [X_W-1:0]   px_6, py_6;
	logic signed [POS_W-1:0] ox_6, oy_6;
	logic                    out_vld_q, rch_q, act_q;
	logic signed [POS_W-1:0] nx_q, ny_q;
	logic signed [HD_W-1:0]  head_q;

	// the whole pipeline moves when the output register can take an item
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// input unpack and differences
	assign in_cx  = s_tdata[mtt_pkg::IX_CX +: POS_W];
	assign in_cy  = s_tdata[mtt_pkg::IX_CY +: POS_W];
	assign in_tgx = s_tdata[mtt_pkg::IX_TX +: TGT_W];
	assign in_tgy = s_tdata[mtt_pkg::IX_TY +: TGT_W];
	assign in_spd = s_tdata[mtt_pkg::IX_SPD +: SPD_W];
	assign in_dly = s_tdata[mtt_pkg::IX_DLY +: 32];
	assign in_now = s_tdata[mtt_pkg::IX_NOW +: 32];
	assign in_dx  = (D_W'(in_tgx) <<< FRAC_BITS) - D_W'(in_cx);
	assign in_dy  = (D_W'(in_tgy) <<< FRAC_BITS) - D_W'(in_cy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1  <= in_cx;
			cy_s1  <= in_cy;
			tgx_s1 <= in_tgx;
			tgy_s1 <= in_tgy;
			spd_s1 <= in_spd;
			act_s1 <= !(in_dly > in_now);
			dx_s1  <= in_dx;
			dy_s1  <= in_dy;
		end
	end

	// heading
	assign sba_in = {cx_s1, cy_s1, tgx_s1, tgy_s1, spd_s1, act_s1, dx_s1, dy_s1};

	mtt_cordic #(
		.D_W    (D_W),
		.STAGES (CORDIC_STAGES),
		.SB_W   (SBA_W)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s1),
		.dx      (dx_s1),
		.dy      (dy_s1),
		.sb_in   (sba_in),
		.out_vld (v_c),
		.heading (head_c),
		.sb_out  (sba_out)
	);

	assign {cx_c, cy_c, tgx_c, tgy_c, spd_c, act_c, dx_c, dy_c} = sba_out;
	assign adx_c = dx_c[D_W-1] ? D_W'(-dx_c) : D_W'(dx_c);
	assign ady_c = dy_c[D_W-1] ? D_W'(-dy_c) : D_W'(dy_c);

	// squares and speed products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s2   <= cx_c;
			cy_s2   <= cy_c;
			tgx_s2  <= tgx_c;
			tgy_s2  <= tgy_c;
			spd_s2  <= spd_c;
			act_s2  <= act_c;
			head_s2 <= head_c;
			negx_s2 <= dx_c[D_W-1];
			negy_s2 <= dy_c[D_W-1];
			dxsq_s2 <= SQ_W'(adx_c) * SQ_W'(adx_c);
			dysq_s2 <= SQ_W'(ady_c) * SQ_W'(ady_c);
			pax_s2  <= P_W'(adx_c) * P_W'(spd_c);
			pay_s2  <= P_W'(ady_c) * P_W'(spd_c);
		end
	end

	// squared distance and the far test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3    <= cx_s2;
			cy_s3    <= cy_s2;
			tgx_s3   <= tgx_s2;
			tgy_s3   <= tgy_s2;
			spd_s3   <= spd_s2;
			act_s3   <= act_s2;
			head_s3  <= head_s2;
			negx_s3  <= negx_s2;
			negy_s3  <= negy_s2;
			pax_s3   <= pax_s2;
			pay_s3   <= pay_s2;
			sumsq_s3 <= dxsq_s2 + dysq_s2;
			norm_s3  <= (dxsq_s2 + dysq_s2) > NORM_LIM;
		end
	end

	// distance
	assign sbb_in = {cx_s3, cy_s3, tgx_s3, tgy_s3, spd_s3, act_s3, head_s3,
		pax_s3, pay_s3, negx_s3, negy_s3, norm_s3};

	mtt_sqrt #(
		.IN_W (SQ_W),
		.R_W  (D_W),
		.SB_W (SBB_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.radicand (sumsq_s3),
		.sb_in    (sbb_in),
		.out_vld  (v_r),
		.root     (dist_r),
		.sb_out   (sbb_out)
	);

	assign {cx_r, cy_r, tgx_r, tgy_r, spd_r, act_r, head_r,
		pax_r, pay_r, negx_r, negy_r, norm_r} = sbb_out;

	// divisor is twice the distance when far, else a fixed shift
	assign den_r  = norm_r ? {dist_r, 1'b0} : (DEN_W'(1) << (FRAC_BITS + 1));
	assign half_r = norm_r ? DEN_W'(dist_r) : (DEN_W'(1) << FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s4   <= cx_r;
			cy_s4   <= cy_r;
			tgx_s4  <= tgx_r;
			tgy_s4  <= tgy_r;
			spd_s4  <= spd_r;
			act_s4  <= act_r;
			head_s4 <= head_r;
			negx_s4 <= negx_r;
			negy_s4 <= negy_r;
			den_s4  <= den_r;
			numx_s4 <= N_W'(pax_r) + N_W'(half_r);
			numy_s4 <= N_W'(pay_r) + N_W'(half_r);
		end
	end

	// step magnitudes
	assign sbc_in = {cx_s4, cy_s4, tgx_s4, tgy_s4, spd_s4, act_s4, head_s4, negx_s4, negy_s4};

	mtt_div #(
		.N_W   (N_W),
		.DEN_W (DEN_W),
		.Q_W   (Q_W),
		.SB_W  (SBC_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s4),
		.num_a   (numx_s4),
		.num_b   (numy_s4),
		.den     (den_s4),
		.sb_in   (sbc_in),
		.out_vld (v_d),
		.quo_a   (qx_d),
		.quo_b   (qy_d),
		.sb_out  (sbc_out)
	);

	assign {cx_d, cy_d, tgx_d, tgy_d, spd_d, act_d, head_d, negx_d, negy_d} = sbc_out;

	// new point and its error to the target
	assign sx_d = negx_d ? -$signed({1'b0, qx_d}) : $signed({1'b0, qx_d});
	assign sy_d = negy_d ? -$signed({1'b0, qy_d}) : $signed({1'b0, qy_d});
	assign nx_d = X_W'(cx_d) + X_W'(sx_d);
	assign ny_d = X_W'(cy_d) + X_W'(sy_d);
	assign tx_d = X_W'(tgx_d) <<< FRAC_BITS;
	assign ty_d = X_W'(tgy_d) <<< FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s5   <= cx_d;
			cy_s5   <= cy_d;
			spd_s5  <= spd_d;
			act_s5  <= act_d;
			head_s5 <= head_d;
			nx_s5   <= nx_d;
			ny_s5   <= ny_d;
			tx_s5   <= tx_d;
			ty_s5   <= ty_d;
			ex_s5   <= E_W'(tx_d) - E_W'(nx_d);
			ey_s5   <= E_W'(ty_d) - E_W'(ny_d);
		end
	end

	// error squares against the squared speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s6    <= cx_s5;
			cy_s6    <= cy_s5;
			act_s6   <= act_s5;
			head_s6  <= head_s5;
			nx_s6    <= nx_s5;
			ny_s6    <= ny_s5;
			tx_s6    <= tx_s5;
			ty_s6    <= ty_s5;
			exsq_s6  <= ESQ_W'(ex_s5 * ex_s5);
			eysq_s6  <= ESQ_W'(ey_s5 * ey_s5);
			spdsq_s6 <= (2 * SPD_W)'(spd_s5) * (2 * SPD_W)'(spd_s5);
		end
	end

	// reached test, snap and clamp
	assign rem4_6 = (RC_W'(exsq_s6) + RC_W'(eysq_s6)) << 2;
	assign rch_6  = rem4_6 <= RC_W'(spdsq_s6);
	assign px_6   = rch_6 ? tx_s6 : nx_s6;
	assign py_6   = rch_6 ? ty_s6 : ny_s6;

	always_comb begin
		if (px_6 > X_W'(mtt_pkg::POS_MAX)) begin
			ox_6 = mtt_pkg::POS_MAX;
		end else if (px_6 < X_W'(mtt_pkg::POS_MIN)) begin
			ox_6 = mtt_pkg::POS_MIN;
		end else begin
			ox_6 = POS_W'(px_6);
		end
		if (py_6 > X_W'(mtt_pkg::POS_MAX)) begin
			oy_6 = mtt_pkg::POS_MAX;
		end else if (py_6 < X_W'(mtt_pkg::POS_MIN)) begin
			oy_6 = mtt_pkg::POS_MIN;
		end else begin
			oy_6 = POS_W'(py_6);
		end
	end

	// output register; an idle mover passes its position through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_q  <= act_s6;
			nx_q   <= act_s6 ? ox_6 : cx_s6;
			ny_q   <= act_s6 ? oy_6 : cy_s6;
			head_q <= act_s6 ? head_s6 : '0;
			rch_q  <= act_s6 && rch_6;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(mtt_pkg::M_DATA_W - mtt_pkg::OUT_USED_W){1'b0}},
		act_q, rch_q, head_q, ny_q, nx_q};

endmodule

FILE: rtl/mtt_cordic.sv
`timescale 1ns / 1ps

module mtt_cordic #(
	parameter int D_W    = 22,
	parameter int STAGES = 16,
	parameter int SB_W   = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic signed [D_W-1:0]              dx,
	input  logic signed [D_W-1:0]              dy,
	input  logic [SB_W-1:0]                    sb_in,
	output logic                               out_vld,
	output logic signed [mtt_pkg::HEAD_W-1:0]  heading,
	output logic [SB_W-1:0]                    sb_out
);

	localparam int C_W = D_W + mtt_pkg::PRESCALE + 2;
	localparam int Z_W = mtt_pkg::Z_W;

	logic signed [C_W-1:0] x_s [0:STAGES];
	logic signed [C_W-1:0] y_s [0:STAGES];
	logic signed [Z_W-1:0] z_s [0:STAGES];
	logic [SB_W-1:0]       sb_s [0:STAGES];
	logic                  v_s [0:STAGES];

	logic signed [C_W-1:0] x_in, y_in, x_pre, y_pre;
	logic signed [Z_W-1:0] z_pre, z_rnd, h_full;
	logic signed [mtt_pkg::HEAD_W-1:0] h_sat;
	logic                  out_vld_q;
	logic signed [mtt_pkg::HEAD_W-1:0] heading_q;
	logic [SB_W-1:0]       sb_q;

	// scale up and fold the left half plane by a quarter turn
	assign x_in = C_W'(dx) <<< mtt_pkg::PRESCALE;
	assign y_in = C_W'(dy) <<< mtt_pkg::PRESCALE;

	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = mtt_pkg::Z_QUARTER;
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -mtt_pkg::Z_QUARTER;
			end
		end
	end

	// entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= x_pre;
			y_s[0]  <= y_pre;
			z_s[0]  <= z_pre;
			sb_s[0] <= sb_in;
		end
	end

	// one vectoring rotation per stage, idle once y is zero
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [C_W-1:0] xn, yn;
		logic signed [Z_W-1:0] zn;

		always_comb begin
			xn = x_s[i];
			yn = y_s[i];
			zn = z_s[i];
			if (y_s[i] > 0) begin
				xn = x_s[i] + (y_s[i] >>> i);
				yn = y_s[i] - (x_s[i] >>> i);
				zn = z_s[i] + mtt_pkg::atan_entry(i);
			end else if (y_s[i] < 0) begin
				xn = x_s[i] - (y_s[i] >>> i);
				yn = y_s[i] + (x_s[i] >>> i);
				zn = z_s[i] - mtt_pkg::atan_entry(i);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1]  <= xn;
				y_s[i+1]  <= yn;
				z_s[i+1]  <= zn;
				sb_s[i+1] <= sb_s[i];
			end
		end
	end

	// round to 1/128 degree and clamp
	assign z_rnd  = z_s[STAGES] + mtt_pkg::HEAD_RND;
	assign h_full = z_rnd >>> mtt_pkg::HEAD_SH;

	always_comb begin
		if (h_full > Z_W'(mtt_pkg::HEAD_MAX)) begin
			h_sat = mtt_pkg::HEAD_MAX;
		end else if (h_full < -Z_W'(mtt_pkg::HEAD_MAX)) begin
			h_sat = -mtt_pkg::HEAD_MAX;
		end else begin
			h_sat = mtt_pkg::HEAD_W'(h_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= v_s[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			heading_q <= h_sat;
			sb_q      <= sb_s[STAGES];
		end
	end

	assign out_vld = out_vld_q;
	assign heading = heading_q;
	assign sb_out  = sb_q;

endmodule

FILE: rtl/mtt_sqrt.sv
`timescale 1ns / 1ps

module mtt_sqrt #(
	parameter int IN_W = 44,
	parameter int R_W  = 22,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [IN_W-1:0] radicand,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_vld,
	output logic [R_W-1:0]  root,
	output logic [SB_W-1:0] sb_out
);

	localparam int W = IN_W + 2;

	logic [W-1:0]    rem_s  [0:R_W];
	logic [R_W-1:0]  root_s [0:R_W];
	logic [SB_W-1:0] sb_s   [0:R_W];
	logic            v_s    [0:R_W];

	logic            out_vld_q;
	logic [R_W-1:0]  root_q;
	logic [SB_W-1:0] sb_q;

	assign rem_s[0]  = W'(radicand);
	assign root_s[0] = '0;
	assign sb_s[0]   = sb_in;
	assign v_s[0]    = in_vld;

	// one root bit per stage, highest first
	for (genvar j = 0; j < R_W; j++) begin : g_bit
		localparam int K = R_W - 1 - j;
		logic [W-1:0] trial;
		logic         take;

		assign trial = (W'(root_s[j]) << (K + 1)) + (W'(1) << (2 * K));
		assign take  = rem_s[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_s[j] - trial : rem_s[j];
				root_s[j+1] <= take ? (root_s[j] | (R_W'(1) << K)) : root_s[j];
				sb_s[j+1]   <= sb_s[j];
			end
		end
	end

	// round to nearest: remainder above the floor root means upper half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= v_s[R_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_q <= (rem_s[R_W] > W'(root_s[R_W])) ? root_s[R_W] + R_W'(1) : root_s[R_W];
			sb_q   <= sb_s[R_W];
		end
	end

	assign out_vld = out_vld_q;
	assign root    = root_q;
	assign sb_out  = sb_q;

endmodule

FILE: rtl/mtt_div.sv
`timescale 1ns / 1ps

module mtt_div #(
	parameter int N_W   = 39,
	parameter int DEN_W = 23,
	parameter int Q_W   = 17,
	parameter int SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [N_W-1:0]   num_a,
	input  logic [N_W-1:0]   num_b,
	input  logic [DEN_W-1:0] den,
	input  logic [SB_W-1:0]  sb_in,
	output logic             out_vld,
	output logic [Q_W-1:0]   quo_a,
	output logic [Q_W-1:0]   quo_b,
	output logic [SB_W-1:0]  sb_out
);

	localparam int W = ((N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W) + 1;

	logic [W-1:0]     ra_s  [0:Q_W];
	logic [W-1:0]     rb_s  [0:Q_W];
	logic [Q_W-1:0]   qa_s  [0:Q_W];
	logic [Q_W-1:0]   qb_s  [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [SB_W-1:0]  sb_s  [0:Q_W];
	logic             v_s   [0:Q_W];

	assign ra_s[0]  = W'(num_a);
	assign rb_s[0]  = W'(num_b);
	assign qa_s[0]  = '0;
	assign qb_s[0]  = '0;
	assign den_s[0] = den;
	assign sb_s[0]  = sb_in;
	assign v_s[0]   = in_vld;

	// restoring division, one quotient bit per stage for both components
	for (genvar j = 0; j < Q_W; j++) begin : g_bit
		localparam int I = Q_W - 1 - j;
		logic [W-1:0] dsh;
		logic         ta, tb;

		assign dsh = W'(den_s[j]) << I;
		assign ta  = ra_s[j] >= dsh;
		assign tb  = rb_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[j+1]  <= ta ? ra_s[j] - dsh : ra_s[j];
				rb_s[j+1]  <= tb ? rb_s[j] - dsh : rb_s[j];
				qa_s[j+1]  <= qa_s[j] | (Q_W'(ta) << I);
				qb_s[j+1]  <= qb_s[j] | (Q_W'(tb) << I);
				den_s[j+1] <= den_s[j];
				sb_s[j+1]  <= sb_s[j];
			end
		end
	end

	assign out_vld = v_s[Q_W];
	assign quo_a   = qa_s[Q_W];
	assign quo_b   = qb_s[Q_W];
	assign sb_out  = sb_s[Q_W];

endmodule

FILE: rtl/mtt_chk.sv
`timescale 1ns / 1ps

module mtt_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [mtt_pkg::S_DATA_W-1:0] s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mtt_pkg::M_DATA_W-1:0] m_tdata
);

	logic signed [mtt_pkg::HEAD_W-1:0] head;
	logic                              rch, act;

	assign head = m_tdata[mtt_pkg::OX_HD +: mtt_pkg::HEAD_W];
	assign rch  = m_tdata[mtt_pkg::OX_RCH];
	assign act  = m_tdata[mtt_pkg::OX_ACT];

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a held result blocks new items
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// an offered item waits unchanged until taken
	a_offer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("offered item changed before accept");

	// an idle mover reports no heading and no arrival
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !act |-> head == '0 && !rch)
		else $error("idle mover with heading or reached");

	// heading stays in the half-turn range
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> head <= mtt_pkg::HEAD_MAX && head >= -mtt_pkg::HEAD_MAX)
		else $error("heading out of range");

endmodule

bind move_toward_target_step_unit mtt_chk u_mtt_chk (.*);

FILE: bench/mtt_checker.sv
`timescale 1ns / 1ps

module mtt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [mtt_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [mtt_pkg::M_DATA_W-1:0]  m_tdata,
	output int                            fail_count,
	output int                            pending
);

	localparam int FRAC = 8;
	localparam int STAGES = 16;

	typedef struct packed {
		logic signed [mtt_pkg::POS_W-1:0]  nx;
		logic signed [mtt_pkg::POS_W-1:0]  ny;
		logic signed [mtt_pkg::HEAD_W-1:0] head;
		logic                              reached;
		logic                              active;
	} step_t;

	step_t expected_steps[$];

	// atan(2^-i) in degrees times 2^16
	longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_div(longint num, longint den);
		if (num >= 0)
			return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint sqrt_nearest(longint v);
		longint r, b, x;
		r = 0;
		b = 64'sd1 <<< 62;
		x = v;
		while (b > x)
			b = b >>> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		if (v - r * r > r)
			r++;
		return r;
	endfunction

	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, t, nx, ny;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		// fold the left half plane onto the right one
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = 90 * 65536;
			end else begin
				x = -y; y = t; z = -90 * 65536;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y == 0)
				break;
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + atan_deg[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - atan_deg[i];
			end
			x = nx;
			y = ny;
		end
		return clamp((z + 256) >>> 9, -23040, 23040);
	endfunction

	function automatic step_t predict_step(logic [mtt_pkg::S_DATA_W-1:0] d);
		step_t r;
		longint cx, cy, tx, ty, spd, dx, dy, sx, sy, nx, ny, ex, ey, sumsq, dlen, den;
		logic [mtt_pkg::TIME_W-1:0] dly, now;
		cx = longint'($signed(d[mtt_pkg::IX_CX +: mtt_pkg::POS_W]));
		cy = longint'($signed(d[mtt_pkg::IX_CY +: mtt_pkg::POS_W]));
		tx = longint'($signed(d[mtt_pkg::IX_TX +: mtt_pkg::TGT_W])) * 256;
		ty = longint'($signed(d[mtt_pkg::IX_TY +: mtt_pkg::TGT_W])) * 256;
		spd = longint'(d[mtt_pkg::IX_SPD +: mtt_pkg::SPD_W]);
		dly = d[mtt_pkg::IX_DLY +: mtt_pkg::TIME_W];
		now = d[mtt_pkg::IX_NOW +: mtt_pkg::TIME_W];
		// mover not launched yet passes through
		if (dly > now) begin
			r.nx = cx[mtt_pkg::POS_W-1:0];
			r.ny = cy[mtt_pkg::POS_W-1:0];
			r.head = '0;
			r.reached = 1'b0;
			r.active = 1'b0;
			return r;
		end
		dx = tx - cx;
		dy = ty - cy;
		r.head = mtt_pkg::HEAD_W'(bearing(dx, dy));
		sumsq = dx * dx + dy * dy;
		if (sumsq > (64'sd2 <<< FRAC) * (64'sd2 <<< FRAC)) begin
			dlen = sqrt_nearest(sumsq);
			sx = round_div(dx * spd, 2 * dlen);
			sy = round_div(dy * spd, 2 * dlen);
		end else begin
			den = 64'sd1 <<< (FRAC + 1);
			sx = round_div(dx * spd, den);
			sy = round_div(dy * spd, den);
		end
		nx = cx + sx;
		ny = cy + sy;
		ex = tx - nx;
		ey = ty - ny;
		r.reached = 4 * (ex * ex + ey * ey) <= spd * spd;
		if (r.reached) begin
			nx = tx;
			ny = ty;
		end
		r.nx = mtt_pkg::POS_W'(clamp(nx, -1048576, 1048575));
		r.ny = mtt_pkg::POS_W'(clamp(ny, -1048576, 1048575));
		r.active = 1'b1;
		return r;
	endfunction

	initial fail_count = 0;
	assign pending = expected_steps.size();

	// predict on input accept, compare on output accept
	always @(posedge clk) begin
		step_t e, a;
		if (arst_n && s_tvalid && s_tready)
			expected_steps.push_back(predict_step(s_tdata));
		if (arst_n && m_tvalid && m_tready) begin
			a.nx = m_tdata[mtt_pkg::OX_NX +: mtt_pkg::POS_W];
			a.ny = m_tdata[mtt_pkg::OX_NY +: mtt_pkg::POS_W];
			a.head = m_tdata[mtt_pkg::OX_HD +: mtt_pkg::HEAD_W];
			a.reached = m_tdata[mtt_pkg::OX_RCH];
			a.active = m_tdata[mtt_pkg::OX_ACT];
			if (expected_steps.size() == 0) begin
				$error("result with no mover pending: %h", m_tdata);
				fail_count++;
			end else begin
				e = expected_steps.pop_front();
				if (a.nx !== e.nx) begin
					$error("new_x expected %0d got %0d", e.nx, a.nx);
					fail_count++;
				end
				if (a.ny !== e.ny) begin
					$error("new_y expected %0d got %0d", e.ny, a.ny);
					fail_count++;
				end
				if (a.head !== e.head) begin
					$error("heading expected %0d got %0d", e.head, a.head);
					fail_count++;
				end
				if (a.reached !== e.reached) begin
					$error("reached expected %0d got %0d", e.reached, a.reached);
					fail_count++;
				end
				if (a.active !== e.active) begin
					$error("active expected %0d got %0d", e.active, a.active);
					fail_count++;
				end
			end
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_MOVERS = 1280;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POS_W = mtt_pkg::POS_W;
	localparam int TGT_W = mtt_pkg::TGT_W;
	localparam int SPD_W = mtt_pkg::SPD_W;
	localparam int TIME_W = mtt_pkg::TIME_W;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [mtt_pkg::S_DATA_W-1:0]  s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [mtt_pkg::M_DATA_W-1:0]  m_tdata;
	int                            fail_count;
	int                            pending;
	int                            cycles;
	bit                            long_hold;

	move_toward_target_step_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	mtt_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("move_toward_target_step_unit test failed");
			$finish;
		end
	end

	function automatic logic [mtt_pkg::S_DATA_W-1:0] pack_mover(logic [POS_W-1:0] cx,
			logic [POS_W-1:0] cy, logic [TGT_W-1:0] tx, logic [TGT_W-1:0] ty,
			logic [SPD_W-1:0] spd, logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now);
		logic [mtt_pkg::S_DATA_W-1:0] d;
		d = '0;
		d[mtt_pkg::IX_CX +: POS_W] = cx;
		d[mtt_pkg::IX_CY +: POS_W] = cy;
		d[mtt_pkg::IX_TX +: TGT_W] = tx;
		d[mtt_pkg::IX_TY +: TGT_W] = ty;
		d[mtt_pkg::IX_SPD +: SPD_W] = spd;
		d[mtt_pkg::IX_DLY +: TIME_W] = dly;
		d[mtt_pkg::IX_NOW +: TIME_W] = now;
		return d;
	endfunction

	// offer one mover after a random gap, return at its accept edge
	task automatic offer_mover(logic [mtt_pkg::S_DATA_W-1:0] d);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// a mover near its target, where stepping and snapping happen
	function automatic logic [mtt_pkg::S_DATA_W-1:0] near_mover();
		logic [TGT_W-1:0] tx, ty;
		logic [POS_W-1:0] cx, cy;
		logic [TIME_W-1:0] now, dly;
		int span;
		span = 1 << $urandom_range(2, 20);
		tx = TGT_W'($urandom);
		ty = TGT_W'($urandom);
		cx = POS_W'(longint'($signed(tx)) * 256 + $urandom_range(0, 2 * span) - span);
		cy = POS_W'(longint'($signed(ty)) * 256 + $urandom_range(0, 2 * span) - span);
		now = $urandom;
		dly = ($urandom_range(0, 5) == 0) ? now : $urandom_range(0, now);
		return pack_mover(cx, cy, tx, ty, SPD_W'($urandom_range(0, 4 * span)), dly, now);
	endfunction

	// receiver: random stalls and one long hold-off
	initial begin
		int w;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	initial begin
		logic [TGT_W-1:0] tmax, tmin;
		logic [POS_W-1:0] pmax, pmin;
		s_tvalid = 1'b0;
		s_tdata = '0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tmax = {1'b0, {(TGT_W-1){1'b1}}};
		tmin = {1'b1, {(TGT_W-1){1'b0}}};
		pmax = mtt_pkg::POS_MAX;
		pmin = mtt_pkg::POS_MIN;

		// directed movers
		offer_mover(pack_mover(POS_W'(100), POS_W'(200), 12'd5, 12'd5, 16'h0200, 32'd10, 32'd9));
		offer_mover(pack_mover(pmax, pmin, tmax, tmin, '1, '1, 32'd0));
		offer_mover(pack_mover(POS_W'(1280), POS_W'(1280), 12'd5, 12'd5, 16'h0100, 32'd7, 32'd7));
		offer_mover(pack_mover(POS_W'(1000), POS_W'(1300), 12'd5, 12'd5, 16'h0100, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(1280), POS_W'(1000), 12'd5, 12'd5, 16'h0000, 32'd0, 32'd1));
		offer_mover(pack_mover(pmax, pmax, tmax, tmax, '1, 32'd0, '1));
		offer_mover(pack_mover(pmin, pmin, tmin, tmin, '1, 32'd0, '1));
		offer_mover(pack_mover(pmax, pmin, tmin, tmax, '1, 32'd0, '1));
		offer_mover(pack_mover(pmin, pmax, tmax, tmin, 16'h0001, '1, '1));
		offer_mover(pack_mover(pmin, '0, tmax, '0, '1, 32'd0, 32'd0));
		offer_mover(pack_mover('0, pmin, '0, tmax, 16'h8000, 32'd0, 32'd0));
		offer_mover(pack_mover(pmax, '0, tmin, '0, 16'h8000, 32'd0, 32'd0));
		offer_mover(pack_mover('0, pmax, '0, tmin, 16'h0400, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(-300), POS_W'(-300), '0, '0, 16'h0400, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(300), POS_W'(-700), '0, '0, 16'h0100, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(-513), POS_W'(0), '0, '0, 16'h0300, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(0), POS_W'(512), '0, '0, 16'h0080, 32'd0, 32'd0));
		offer_mover(pack_mover(POS_W'(1), POS_W'(-1), '0, '0, 16'h0001, 32'd0, 32'd0));
		offer_mover(pack_mover('1, '1, '1, '1, '1, '1, '1));

		// random movers, mostly near their targets
		for (int n = 0; n < RANDOM_MOVERS; n++) begin
			if (n == 300)
				long_hold = 1'b1;
			if (n == 700) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1: offer_mover(mtt_pkg::S_DATA_W'({$urandom, $urandom, $urandom,
					$urandom, $urandom}));
				2: offer_mover(pack_mover(POS_W'($urandom), POS_W'($urandom),
					TGT_W'($urandom), TGT_W'($urandom), SPD_W'($urandom),
					32'hffff_ffff - $urandom_range(0, 1000), $urandom_range(0, 1000)));
				default: offer_mover(near_mover());
			endcase
		end
		s_tvalid <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("move_toward_target_step_unit test passed");
		else
			$display("move_toward_target_step_unit test failed");
		$finish;
	end

endmodule
